/* hw/rtl/aescbc_pkg.sv */
// AES-128 CBC engine package: types, S-box tables, round helper functions.
// No dependencies; used by every module of the engine.
package aescbc_pkg;

	localparam int BlockW = 128;
	localparam int HalfW  = 64;
	localparam int Rounds = 10;
	localparam int RoundW = 4;
	localparam int QueueDepth = 2;
	localparam int CfgIdxW = 3;

	typedef enum logic [CfgIdxW-1:0] {
		REG_KEY_HIGH = 3'd0,
		REG_KEY_LOW  = 3'd1,
		REG_IV_HIGH  = 3'd2,
		REG_IV_LOW   = 3'd3,
		REG_DECRYPT  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_ROUND = 2'd1,
		ST_DONE  = 2'd2
	} core_state_t;

	// queued job: block data with its first-block flag for chaining
	typedef struct packed {
		logic [BlockW-1:0] data;
		logic              first;
	} job_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [3:0] b);
		logic [7:0] p, x;
		p = 8'h00;
		x = a;
		for (int i = 0; i < 4; i++) begin
			if (b[i]) p = p ^ x;
			x = xtime(x);
		end
		gmul = p;
	endfunction

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	// byte i of a state sits at bits [127-8i -: 8]
	function automatic logic [7:0] byte_at(input logic [BlockW-1:0] s, input int i);
		byte_at = s[BlockW-1-8*i -: 8];
	endfunction

	function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
			input logic last);
		logic [7:0] t [16];
		logic [BlockW-1:0] o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				t[r+4*c] = SBOX[byte_at(s, r + 4*((c + r) % 4))];
		for (int c = 0; c < 4; c++) begin
			if (last) begin
				for (int r = 0; r < 4; r++) o[BlockW-1-8*(4*c+r) -: 8] = t[4*c+r];
			end else begin
				o[BlockW-1-8*(4*c)   -: 8] = gmul(t[4*c],4'd2)^gmul(t[4*c+1],4'd3)
					^t[4*c+2]^t[4*c+3];
				o[BlockW-1-8*(4*c+1) -: 8] = t[4*c]^gmul(t[4*c+1],4'd2)
					^gmul(t[4*c+2],4'd3)^t[4*c+3];
				o[BlockW-1-8*(4*c+2) -: 8] = t[4*c]^t[4*c+1]^gmul(t[4*c+2],4'd2)
					^gmul(t[4*c+3],4'd3);
				o[BlockW-1-8*(4*c+3) -: 8] = gmul(t[4*c],4'd3)^t[4*c+1]^t[4*c+2]
					^gmul(t[4*c+3],4'd2);
			end
		end
		enc_round = o;
	endfunction

	function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] s);
		logic [7:0] a0, a1, a2, a3;
		logic [BlockW-1:0] o;
		for (int c = 0; c < 4; c++) begin
			a0 = byte_at(s, 4*c);   a1 = byte_at(s, 4*c+1);
			a2 = byte_at(s, 4*c+2); a3 = byte_at(s, 4*c+3);
			o[BlockW-1-8*(4*c)   -: 8] = gmul(a0,4'd14)^gmul(a1,4'd11)^gmul(a2,4'd13)
				^gmul(a3,4'd9);
			o[BlockW-1-8*(4*c+1) -: 8] = gmul(a0,4'd9)^gmul(a1,4'd14)^gmul(a2,4'd11)
				^gmul(a3,4'd13);
			o[BlockW-1-8*(4*c+2) -: 8] = gmul(a0,4'd13)^gmul(a1,4'd9)^gmul(a2,4'd14)
				^gmul(a3,4'd11);
			o[BlockW-1-8*(4*c+3) -: 8] = gmul(a0,4'd11)^gmul(a1,4'd13)^gmul(a2,4'd9)
				^gmul(a3,4'd14);
		end
		inv_mix = o;
	endfunction

	// inverse shift rows plus inverse S-box
	function automatic logic [BlockW-1:0] inv_shsub(input logic [BlockW-1:0] s);
		logic [BlockW-1:0] o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[BlockW-1-8*(r + 4*((c + r) % 4)) -: 8] = INV_SBOX[byte_at(s, r + 4*c)];
		inv_shsub = o;
	endfunction

	function automatic logic [7:0] rcon_next(input logic [7:0] r);
		rcon_next = xtime(r);
	endfunction

	function automatic logic [7:0] rcon_prev(input logic [7:0] r);
		rcon_prev = r[0] ? ({1'b1, r[7:1]} ^ 8'h0d) : {1'b0, r[7:1]};
	endfunction

	function automatic logic [31:0] sub_rot(input logic [31:0] w, input logic [7:0] rc);
		sub_rot = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
	endfunction

	function automatic logic [BlockW-1:0] key_fwd(input logic [BlockW-1:0] k,
			input logic [7:0] rc);
		logic [31:0] w0, w1, w2, w3;
		w0 = k[127:96] ^ sub_rot(k[31:0], rc);
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		key_fwd = {w0, w1, w2, w3};
	endfunction

	// rc is the constant that produced k from its predecessor
	function automatic logic [BlockW-1:0] key_back(input logic [BlockW-1:0] k,
			input logic [7:0] rc);
		logic [31:0] w1, w2, w3, w0;
		w3 = k[31:0] ^ k[63:32];
		w2 = k[63:32] ^ k[95:64];
		w1 = k[95:64] ^ k[127:96];
		w0 = k[127:96] ^ sub_rot(w3, rc);
		key_back = {w0, w1, w2, w3};
	endfunction

endpackage

/* hw/rtl/aes128_cbc_engine_top.sv */
// Top level of the AES-128 CBC engine: stream ports, registers, assertions.
// Depends on aescbc_pkg, aescbc_queue and aescbc_core.
//
// AES-128 in CBC mode. Write key, IV and mode through the cfg channel while
// idle, then stream 128-bit blocks in on s_axis (byte 0 in tdata[63:56]);
// set tuser on the first block of a message to restart chaining from the IV.
// Each block passes through the round engine as a load step, the ten AES
// rounds (one AES round per cycle through a shared round unit, round keys
// computed on the fly) and a result latch that waits for a free output
// register. After reset and after every key change the engine first rolls
// the key schedule forward to the last round key (the starting key for
// decryption) and starts no block until that is done. A two-entry queue
// sits in front, so up to two further blocks can be taken while one is in
// flight and its result waits on m_axis. Result beats leave in input order.
module aes128_cbc_engine_top #(
	parameter int QueueDepth = aescbc_pkg::QueueDepth
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // block_high [63:0], block_low [127:64]
	input  logic         s_axis_tuser,  // first_block
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata,  // result_high [63:0], result_low [127:64]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);
	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic        decrypt_q;
	logic        q_full, q_empty, q_pop;
	logic [127:0] core_out;
	aescbc_pkg::job_t in_job, q_job;

	assign cfg_ready = 1'b1;

	// hold register values; drop writes past the last index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
			decrypt_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				aescbc_pkg::REG_KEY_HIGH: key_high_q <= cfg_data;
				aescbc_pkg::REG_KEY_LOW:  key_low_q  <= cfg_data;
				aescbc_pkg::REG_IV_HIGH:  iv_high_q  <= cfg_data;
				aescbc_pkg::REG_IV_LOW:   iv_low_q   <= cfg_data;
				aescbc_pkg::REG_DECRYPT:  decrypt_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// front end: swap the beat halves into cipher byte order
	assign in_job.data  = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
	assign in_job.first = s_axis_tuser;
	assign s_axis_tready = !q_full;

	aescbc_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(s_axis_tvalid), .push_job(in_job), .full(q_full),
		.pop(q_pop), .empty(q_empty), .pop_job(q_job)
	);

	aescbc_core u_core (
		.clk(clk), .arst_n(arst_n),
		.job_valid(!q_empty), .job(q_job), .job_pop(q_pop),
		.key({key_high_q, key_low_q}), .iv({iv_high_q, iv_low_q}), .decrypt(decrypt_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(core_out)
	);

	// swap the result halves back into beat order
	assign m_axis_tdata = {core_out[63:0], core_out[127:64]};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat dropped under back-pressure");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !s_axis_tready)
		else $error("input taken while queue full");
	a_pop: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("core popped an empty queue");
endmodule

/* hw/rtl/aescbc_queue.sv */
// Two-entry job queue between front end and cipher core.
// Depends on aescbc_pkg.
module aescbc_queue #(
	parameter int Depth = aescbc_pkg::QueueDepth
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  aescbc_pkg::job_t push_job,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output aescbc_pkg::job_t pop_job
);
	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	aescbc_pkg::job_t mem_q [Depth];
	logic [PtrW-1:0] wr_q, rd_q;
	logic [CntW-1:0] cnt_q;

	assign full    = (cnt_q == CntW'(Depth));
	assign empty   = (cnt_q == '0);
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wr_q <= (wr_q == PtrW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (pop && !empty) rd_q <= (rd_q == PtrW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CntW'(push && !full) - CntW'(pop && !empty);
		end
	end
endmodule

/* hw/rtl/aescbc_core.sv */
// Iterative AES-128 round engine with CBC chaining and output register.
// Depends on aescbc_pkg.
module aescbc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             job_valid,
	input  aescbc_pkg::job_t job,
	output logic             job_pop,
	input  logic [127:0]     key,
	input  logic [127:0]     iv,
	input  logic             decrypt,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [127:0]     out_data
);
	aescbc_pkg::core_state_t state_q, state_d;
	logic [127:0] st_q, rk_q, chain_q, ct_q;
	logic [7:0]   rc_q;
	logic [aescbc_pkg::RoundW-1:0] rnd_q;
	logic         dec_q;
	logic [127:0] res_q;
	logic         res_v_q;
	logic [127:0] kx_q, kx_src_q;
	logic [7:0]   kx_rc_q;
	logic [aescbc_pkg::RoundW-1:0] kx_cnt_q;

	logic [127:0] chain_use, last_key, rk_next, st_next;
	logic         load, fin, key_rdy;

	// decryption starts from the final round key: roll forward one round
	// per cycle after reset or a key change, and hold new blocks until done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kx_q     <= '0;
			kx_src_q <= '0;
			kx_rc_q  <= 8'h01;
			kx_cnt_q <= 4'(aescbc_pkg::Rounds);
		end else if (key != kx_src_q) begin
			kx_q     <= key;
			kx_src_q <= key;
			kx_rc_q  <= 8'h01;
			kx_cnt_q <= 4'(aescbc_pkg::Rounds);
		end else if (kx_cnt_q != '0) begin
			kx_q     <= aescbc_pkg::key_fwd(kx_q, kx_rc_q);
			kx_rc_q  <= aescbc_pkg::rcon_next(kx_rc_q);
			kx_cnt_q <= kx_cnt_q - 1'b1;
		end
	end

	assign last_key  = kx_q;
	assign key_rdy   = (kx_cnt_q == '0) && (key == kx_src_q);
	assign chain_use = job.first ? iv : chain_q;
	assign load      = (state_q == aescbc_pkg::ST_IDLE) && job_valid && key_rdy;
	assign fin       = (state_q == aescbc_pkg::ST_DONE) && (!res_v_q || out_ready);
	assign job_pop   = load;

	always_comb begin
		if (!dec_q) begin
			rk_next = aescbc_pkg::key_fwd(rk_q, rc_q);
			st_next = aescbc_pkg::enc_round(st_q, rnd_q == 4'(aescbc_pkg::Rounds)) ^ rk_next;
		end else begin
			rk_next = aescbc_pkg::key_back(rk_q, rc_q);
			st_next = aescbc_pkg::inv_shsub(st_q) ^ rk_next;
			if (rnd_q != 4'(aescbc_pkg::Rounds)) st_next = aescbc_pkg::inv_mix(st_next);
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			aescbc_pkg::ST_IDLE:  if (load) state_d = aescbc_pkg::ST_ROUND;
			aescbc_pkg::ST_ROUND: if (rnd_q == 4'(aescbc_pkg::Rounds)) state_d = aescbc_pkg::ST_DONE;
			aescbc_pkg::ST_DONE:  if (fin) state_d = aescbc_pkg::ST_IDLE;
			default:              state_d = aescbc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aescbc_pkg::ST_IDLE;
			chain_q <= '0;
			res_v_q <= 1'b0;
			rnd_q   <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				rnd_q <= 4'd1;
				if (job.first) chain_q <= iv;
			end else if (state_q == aescbc_pkg::ST_ROUND) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (fin) begin
				res_v_q <= 1'b1;
				chain_q <= dec_q ? ct_q : st_q;
			end else if (out_ready) begin
				res_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dec_q <= decrypt;
			ct_q  <= job.data;
			if (decrypt) begin
				st_q <= job.data ^ last_key;
				rk_q <= last_key;
				rc_q <= 8'h36;
			end else begin
				st_q <= job.data ^ chain_use ^ key;
				rk_q <= key;
				rc_q <= 8'h01;
			end
		end else if (state_q == aescbc_pkg::ST_ROUND) begin
			st_q <= st_next;
			rk_q <= rk_next;
			rc_q <= dec_q ? aescbc_pkg::rcon_prev(rc_q) : aescbc_pkg::rcon_next(rc_q);
			if (dec_q && load == 1'b0 && rnd_q == 4'd1) ct_q <= ct_q;
		end
		if (load && decrypt) res_q <= res_q;
		if (fin) res_q <= dec_q ? (st_q ^ chain_q) : st_q;
	end

	// decrypt chain for the first block must come from iv at load time
	assign out_valid = res_v_q;
	assign out_data  = res_q;
endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// Self-checking regression for aes128_cbc_engine_top: directed and random stream traffic with CBC prediction.
// Depends on aescbc_pkg (register indexes) and the engine RTL.
module testbench;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;
	// indexes past the register file; writes there must be dropped
	localparam logic [2:0] REG_SPARE_A = 3'd5;
	localparam logic [2:0] REG_SPARE_C = 3'd7;
	localparam int SETTLE_CYCLES = 30;
	localparam int STALL_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        first;
	} blk_item_t;

	typedef struct {
		logic [63:0] hi;
		logic [63:0] lo;
	} blk_out_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [127:0] m_axis_tdata;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;

	aes128_cbc_engine_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	blk_item_t   pending_blocks[$];
	blk_out_t    expected_blocks[$];
	logic [7:0]  sbox_fwd [256];
	logic [7:0]  sbox_inv [256];
	logic [63:0] key_hi_sh, key_lo_sh, iv_hi_sh, iv_lo_sh;
	logic        mode_sh;
	logic [63:0] chain_hi, chain_lo;
	int          err_count;
	int          idle_cycles;
	int          hold_ask, hold_seen;
	bit          quiet;
	bit          in_took;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// ---------------- AES arithmetic ----------------
	function automatic logic [7:0] gf_mult(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) p ^= a;
			a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
		end
		return p;
	endfunction

	function automatic logic [7:0] rot8(input logic [7:0] v, input int n);
		return (v << n) | (v >> (8 - n));
	endfunction

	// S-boxes from the field inverse and the affine map
	function automatic void build_sboxes();
		logic [7:0] inv, x, y;
		for (int v = 0; v < 256; v++) begin
			x = 8'(v);
			inv = 8'h01;
			for (int e = 0; e < 254; e++) inv = gf_mult(inv, x);
			if (x == 8'h00) inv = 8'h00;
			y = inv ^ rot8(inv, 1) ^ rot8(inv, 2) ^ rot8(inv, 3) ^ rot8(inv, 4) ^ 8'h63;
			sbox_fwd[v] = y;
			sbox_inv[y] = x;
		end
	endfunction

	function automatic void expand_keys(input logic [127:0] k, output logic [7:0] rk [176]);
		logic [7:0] t [4];
		logic [7:0] rc, tmp;
		rc = 8'h01;
		for (int i = 0; i < 16; i++) rk[i] = k[127-8*i -: 8];
		for (int i = 16; i < 176; i += 4) begin
			for (int j = 0; j < 4; j++) t[j] = rk[i-4+j];
			if (i % 16 == 0) begin
				tmp = t[0];
				t[0] = sbox_fwd[t[1]] ^ rc;
				t[1] = sbox_fwd[t[2]];
				t[2] = sbox_fwd[t[3]];
				t[3] = sbox_fwd[tmp];
				rc = gf_mult(rc, 8'h02);
			end
			for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ t[j];
		end
	endfunction

	function automatic logic [127:0] aes_encrypt(input logic [127:0] k, input logic [127:0] b);
		logic [7:0] rk [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [127:0] o;
		expand_keys(k, rk);
		for (int i = 0; i < 16; i++) s[i] = b[127-8*i -: 8] ^ rk[i];
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 16; i++) s[i] = sbox_fwd[s[i]];
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++) t[w+4*c] = s[w+4*((c+w)%4)];
			for (int c = 0; c < 4; c++) begin
				if (r != 10) begin
					s[4*c]   = gf_mult(t[4*c],2) ^ gf_mult(t[4*c+1],3) ^ t[4*c+2] ^ t[4*c+3];
					s[4*c+1] = t[4*c] ^ gf_mult(t[4*c+1],2) ^ gf_mult(t[4*c+2],3) ^ t[4*c+3];
					s[4*c+2] = t[4*c] ^ t[4*c+1] ^ gf_mult(t[4*c+2],2) ^ gf_mult(t[4*c+3],3);
					s[4*c+3] = gf_mult(t[4*c],3) ^ t[4*c+1] ^ t[4*c+2] ^ gf_mult(t[4*c+3],2);
				end else begin
					for (int w = 0; w < 4; w++) s[4*c+w] = t[4*c+w];
				end
			end
			for (int i = 0; i < 16; i++) s[i] ^= rk[16*r+i];
		end
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
		return o;
	endfunction

	function automatic logic [127:0] aes_decrypt(input logic [127:0] k, input logic [127:0] b);
		logic [7:0] rk [176];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] o;
		expand_keys(k, rk);
		for (int i = 0; i < 16; i++) s[i] = b[127-8*i -: 8] ^ rk[160+i];
		for (int r = 9; r >= 0; r--) begin
			for (int c = 0; c < 4; c++)
				for (int w = 0; w < 4; w++) t[w+4*((c+w)%4)] = s[w+4*c];
			for (int i = 0; i < 16; i++) s[i] = sbox_inv[t[i]] ^ rk[16*r+i];
			if (r != 0) begin
				for (int c = 0; c < 4; c++) begin
					a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
					s[4*c]   = gf_mult(a0,14)^gf_mult(a1,11)^gf_mult(a2,13)^gf_mult(a3,9);
					s[4*c+1] = gf_mult(a0,9)^gf_mult(a1,14)^gf_mult(a2,11)^gf_mult(a3,13);
					s[4*c+2] = gf_mult(a0,13)^gf_mult(a1,9)^gf_mult(a2,14)^gf_mult(a3,11);
					s[4*c+3] = gf_mult(a0,11)^gf_mult(a1,13)^gf_mult(a2,9)^gf_mult(a3,14);
				end
			end
		end
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
		return o;
	endfunction

	// ---------------- monitor and CBC prediction ----------------
	// Sample every channel at the rising edge; inputs only move at the falling edge.
	always @(posedge clk) begin
		logic [127:0] blk, res;
		in_took = arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					aescbc_pkg::REG_KEY_HIGH: key_hi_sh = cfg_data;
					aescbc_pkg::REG_KEY_LOW:  key_lo_sh = cfg_data;
					aescbc_pkg::REG_IV_HIGH:  iv_hi_sh = cfg_data;
					aescbc_pkg::REG_IV_LOW:   iv_lo_sh = cfg_data;
					aescbc_pkg::REG_DECRYPT:  mode_sh = cfg_data[0];
					default: ;
				endcase
			end
			if (in_took) begin
				// first-block flag restarts chaining from the IV
				if (s_axis_tuser) begin
					chain_hi = iv_hi_sh;
					chain_lo = iv_lo_sh;
				end
				blk = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
				if (mode_sh == MODE_DEC) begin
					res = aes_decrypt({key_hi_sh, key_lo_sh}, blk) ^ {chain_hi, chain_lo};
					{chain_hi, chain_lo} = blk;
				end else begin
					res = aes_encrypt({key_hi_sh, key_lo_sh}, blk ^ {chain_hi, chain_lo});
					{chain_hi, chain_lo} = res;
				end
				expected_blocks.push_back('{hi: res[127:64], lo: res[63:0]});
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_blocks.size() == 0) begin
					$error("result beat with nothing expected: %h", m_axis_tdata);
					err_count++;
				end else begin
					blk_out_t e;
					e = expected_blocks.pop_front();
					if (m_axis_tdata[63:0] !== e.hi) begin
						$error("result_high expected %h actual %h", e.hi, m_axis_tdata[63:0]);
						err_count++;
					end
					if (m_axis_tdata[127:64] !== e.lo) begin
						$error("result_low expected %h actual %h", e.lo, m_axis_tdata[127:64]);
						err_count++;
					end
				end
			end
		end
	end

	// ---------------- block driver ----------------
	int send_gap;
	always @(negedge clk) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap = 0;
		end else if (!s_axis_tvalid || in_took) begin
			// advance: the current beat is gone or nothing was offered
			if (send_gap > 0) begin
				send_gap--;
				s_axis_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				send_gap = $urandom_range(1, 14) - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pending_blocks.size() > 0) begin
				blk_item_t it;
				it = pending_blocks.pop_front();
				s_axis_tdata <= {it.lo, it.hi};
				s_axis_tuser <= it.first;
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// ---------------- result receiver ----------------
	int stall_left;
	always @(negedge clk) begin
		if (hold_ask != hold_seen) begin
			// long hold-off: let the queue fill and the input stall
			hold_seen = hold_ask;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 14) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready) || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("aes128_cbc_engine_top regression: fail");
			$finish;
		end
	end

	// ---------------- sequencing ----------------
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold the next writes until the engine has drained and settled
	task automatic drain();
		wait (pending_blocks.size() == 0 && !s_axis_tvalid && expected_blocks.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 9))
			0: return 64'h0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic queue_block(input logic [63:0] hi, input logic [63:0] lo, input logic first);
		pending_blocks.push_back('{hi: hi, lo: lo, first: first});
	endtask

	initial begin
		int n;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = aescbc_pkg::REG_KEY_HIGH;
		cfg_data = '0;
		key_hi_sh = '0; key_lo_sh = '0; iv_hi_sh = '0; iv_lo_sh = '0;
		mode_sh = MODE_ENC;
		chain_hi = '0; chain_lo = '0;
		err_count = 0; idle_cycles = 0;
		hold_ask = 0; hold_seen = 0; stall_left = 0;
		quiet = 1'b0;
		build_sboxes();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: chaining before any first block, from the zero reset state
		queue_block(64'h0, 64'h0, 1'b0);
		queue_block('1, '1, 1'b0);
		drain();
		// standard key and plaintext, then mid-stream IV write not yet in effect
		reg_write(aescbc_pkg::REG_KEY_HIGH, 64'h0001020304050607);
		reg_write(aescbc_pkg::REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
		queue_block(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1);
		queue_block(64'h0, '1, 1'b0);
		drain();
		reg_write(aescbc_pkg::REG_IV_HIGH, '1);
		reg_write(aescbc_pkg::REG_IV_LOW, 64'h0123456789abcdef);
		queue_block('1, 64'h0, 1'b0);
		queue_block(64'h8000000000000001, 64'h1, 1'b1);
		drain();
		// switch direction mid-stream, keeping the chain; wide mode word, odd index
		reg_write(aescbc_pkg::REG_DECRYPT, 64'hfffffffffffffffe | 64'h1);
		reg_write(REG_SPARE_A, '1);
		reg_write(REG_SPARE_C, 64'h5a5a5a5a5a5a5a5a);
		queue_block(64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b0);
		queue_block(64'h0, 64'h0, 1'b1);
		queue_block('1, '1, 1'b0);
		drain();
		reg_write(aescbc_pkg::REG_KEY_HIGH, '1);
		reg_write(aescbc_pkg::REG_KEY_LOW, '1);
		reg_write(aescbc_pkg::REG_DECRYPT, 64'h2);
		queue_block(64'h0, 64'h0, 1'b1);
		queue_block('1, '1, 1'b0);
		drain();

		// random phases
		for (int ph = 0; ph < 14; ph++) begin
			if (ph == 0) begin
				reg_write(aescbc_pkg::REG_KEY_HIGH, 64'h0);
				reg_write(aescbc_pkg::REG_KEY_LOW, 64'h0);
			end else if ($urandom_range(0, 2) != 0) begin
				reg_write(aescbc_pkg::REG_KEY_HIGH, pick_word());
				reg_write(aescbc_pkg::REG_KEY_LOW, pick_word());
			end
			if ($urandom_range(0, 1)) begin
				reg_write(aescbc_pkg::REG_IV_HIGH, pick_word());
				reg_write(aescbc_pkg::REG_IV_LOW, pick_word());
			end
			reg_write(aescbc_pkg::REG_DECRYPT,
				{$urandom, $urandom_range(0, 1) ? 32'h0 : 32'h1} ^ ph[0]);
			if ($urandom_range(0, 3) == 0)
				reg_write(3'($urandom_range(REG_SPARE_A, REG_SPARE_C)), pick_word());
			if (ph == 13) quiet = 1'b1;
			if (ph == 4) hold_ask++;
			n = 130;
			for (int i = 0; i < n; i++)
				queue_block(pick_word(), pick_word(), (i == 0) ? 1'($urandom_range(0, 3) != 0)
					: 1'($urandom_range(0, 9) == 0));
			drain();
		end

		// settle and report
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("aes128_cbc_engine_top regression: pass");
		else
			$display("aes128_cbc_engine_top regression: fail");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/aescbc_pkg.sv
hw/rtl/aescbc_queue.sv
hw/rtl/aescbc_core.sv
hw/rtl/aes128_cbc_engine_top.sv
tb/testbench.sv
